/* rtl/ilha_pkg.sv */
// Shared types and constants of the implicit list heap allocator.
`default_nettype none
package ilha_pkg;

	localparam int          CHUNK_RESET = 4096;
	localparam int          BREAK_RESET = 16 + CHUNK_RESET;
	localparam int          HDR_MIN     = 16;
	localparam logic [31:0] PROLOG_WORD = 32'd9;
	localparam logic [31:0] EPILOG_WORD = 32'd1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLR, OP_LATCH, OP_BP_START, OP_RD_BP, OP_WALK_ADV,
		OP_M_OPEN, OP_RD_NX, OP_N_ADV, OP_WR_MH, OP_WR_MF, OP_M_NEXT,
		OP_G_SET, OP_WR_GH, OP_WR_GF, OP_WR_GE, OP_P_LOAD,
		OP_WR_SH1, OP_WR_SF1, OP_WR_SH2, OP_WR_SF2, OP_WR_NH, OP_WR_NF,
		OP_F_HDR, OP_WR_FH, OP_WR_FF
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic kind_free;
		logic req_zero;
		logic bp_ge_brk;
		logic nx_ge_brk;
		logic r_zero;
		logic r_alloc;
		logic r_fit;
		logic tot_ne_sz;
		logic grow_fail;
		logic split_ok;
		logic f_bad_addr;
		logic f_bad_hdr;
		logic f_ft_bad;
	} stat_t;

	typedef struct packed {
		logic       idle;
		logic       done;
		logic       with_addr;
		logic [1:0] code;
	} res_t;

endpackage
`default_nettype wire

/* rtl/ilha_chan_if.sv */
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ilha_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [16:0] request_bytes;
	logic [15:0] block_addr;
	modport source (output valid, kind, request_bytes, block_addr, input ready);
	modport sink   (input valid, kind, request_bytes, block_addr, output ready);
endinterface

interface ilha_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] payload_addr;
	logic [1:0]  status;
	modport source (output valid, payload_addr, status, input ready);
	modport sink   (input valid, payload_addr, status, output ready);
endinterface
`default_nettype wire

/* rtl/ilha_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module ilha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

/* rtl/ilha_dp.sv */
// Datapath: heap store, walk pointers, break and chunk registers.
`default_nettype none
module ilha_dp import ilha_pkg::*; #(
	parameter int HEAP_BYTES      = 65536,
	parameter int MIN_BLOCK_BYTES = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  wire         in_kind,
	input  wire  [16:0] in_request_bytes,
	input  wire  [15:0] in_block_addr,
	input  wire         cfg_we,
	input  wire  [16:0] cfg_wdata,
	output logic [15:0] bp_low
);
	localparam int BW    = ($clog2(HEAP_BYTES) > 16) ? $clog2(HEAP_BYTES) + 2 : 18;
	localparam int DEPTH = HEAP_BYTES / 4;
	localparam int WAW   = $clog2(DEPTH);
	localparam int MINB  = (MIN_BLOCK_BYTES + 7) / 8 * 8;
	localparam logic [BW-1:0]  HEAP_B   = BW'(HEAP_BYTES);
	localparam logic [BW-1:0]  MIN_B    = BW'(MIN_BLOCK_BYTES);
	localparam logic [BW-1:0]  MINB_B   = BW'(MINB);
	localparam logic [BW-1:0]  HMIN_B   = BW'(HDR_MIN);
	localparam logic [WAW-1:0] W_HDR    = WAW'(3);
	localparam logic [WAW-1:0] W_FTR    = WAW'((BREAK_RESET - 8) / 4);
	localparam logic [WAW-1:0] W_EPI    = WAW'((BREAK_RESET - 4) / 4);
	localparam logic [31:0]    CHUNK_W  = 32'(CHUNK_RESET);

	logic [BW-1:0]  bp_q, nx_q, sz_q, total_q, need_q, brk_q;
	logic [16:0]    chunk_q;
	logic [31:0]    hdr_q;
	logic           kind_q, zero_q;
	logic [WAW-1:0] clr_q;

	logic           mem_we;
	logic [BW-1:0]  mem_a;
	logic [31:0]    mem_wd, rdata;
	logic [BW-1:0]  rsz, gsz, need_d;
	logic [17:0]    ext;
	logic [16:0]    wd;
	logic [BW:0]    brk_sum;
	logic [31:0]    clr_val;

	ilha_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_a[WAW+1:2]),
		.wdata (mem_wd),
		.rdata (rdata)
	);

	assign rsz = rdata[BW-1:0] & ~BW'(7);

	// growth: max(need, chunk) in words, rounded up to an even count
	assign ext     = (18'(need_q) > {1'b0, chunk_q}) ? 18'(need_q) : {1'b0, chunk_q};
	assign wd      = {1'b0, ext[17:2]} + 17'd1;
	assign gsz     = BW'({wd[16:1], 3'b000});
	assign brk_sum = {1'b0, brk_q} + {1'b0, gsz};

	always_comb begin
		need_d = (BW'(in_request_bytes) + BW'(15)) & ~BW'(7);
		if (need_d < MINB_B) begin
			need_d = MINB_B;
		end
	end

	always_comb begin
		if (clr_q == WAW'(1) || clr_q == WAW'(2)) clr_val = PROLOG_WORD;
		else if (clr_q == W_HDR || clr_q == W_FTR) clr_val = CHUNK_W;
		else if (clr_q == W_EPI) clr_val = EPILOG_WORD;
		else clr_val = '0;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_a  = bp_q - BW'(4);
		mem_wd = '0;
		unique case (cmd.op)
			OP_CLR: begin
				mem_we = 1'b1;
				mem_a  = BW'({clr_q, 2'b00});
				mem_wd = clr_val;
			end
			OP_RD_NX: mem_a = nx_q - BW'(4);
			OP_WR_MH: begin
				mem_we = 1'b1;
				mem_wd = 32'(total_q);
			end
			OP_WR_MF: begin
				mem_we = 1'b1;
				mem_a  = bp_q + total_q - BW'(8);
				mem_wd = 32'(total_q);
			end
			OP_WR_GH, OP_WR_FH: begin
				mem_we = 1'b1;
				mem_wd = 32'(sz_q);
			end
			OP_WR_GF, OP_WR_FF: begin
				mem_we = 1'b1;
				mem_a  = bp_q + sz_q - BW'(8);
				mem_wd = 32'(sz_q);
			end
			OP_WR_GE: begin
				mem_we = 1'b1;
				mem_a  = bp_q + sz_q - BW'(4);
				mem_wd = EPILOG_WORD;
			end
			OP_WR_SH1: begin
				mem_we = 1'b1;
				mem_wd = 32'(need_q) | 32'd1;
			end
			OP_WR_SF1: begin
				mem_we = 1'b1;
				mem_a  = bp_q + need_q - BW'(8);
				mem_wd = 32'(need_q) | 32'd1;
			end
			OP_WR_SH2: begin
				mem_we = 1'b1;
				mem_a  = bp_q + need_q - BW'(4);
				mem_wd = 32'(sz_q - need_q);
			end
			OP_WR_SF2: begin
				mem_we = 1'b1;
				mem_a  = bp_q + sz_q - BW'(8);
				mem_wd = 32'(sz_q - need_q);
			end
			OP_WR_NH: begin
				mem_we = 1'b1;
				mem_wd = 32'(sz_q) | 32'd1;
			end
			OP_WR_NF: begin
				mem_we = 1'b1;
				mem_a  = bp_q + sz_q - BW'(8);
				mem_wd = 32'(sz_q) | 32'd1;
			end
			// read the footer while the header checks run
			OP_F_HDR: mem_a = bp_q + rsz - BW'(8);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			brk_q   <= BW'(BREAK_RESET);
			chunk_q <= 17'(CHUNK_RESET);
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if (cmd.op == OP_CLR) begin
				clr_q <= clr_q + WAW'(1);
			end
			if (cmd.op == OP_G_SET) begin
				brk_q <= brk_sum[BW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				kind_q <= in_kind;
				zero_q <= (in_request_bytes == 17'd0);
				need_q <= need_d;
				bp_q   <= BW'(in_block_addr);
			end
			OP_BP_START: bp_q <= BW'(8);
			OP_WALK_ADV: bp_q <= bp_q + rsz;
			OP_M_OPEN: begin
				sz_q    <= rsz;
				total_q <= rsz;
				nx_q    <= bp_q + rsz;
			end
			OP_N_ADV: begin
				total_q <= total_q + rsz;
				nx_q    <= nx_q + rsz;
			end
			OP_WR_MF, OP_M_NEXT: bp_q <= bp_q + total_q;
			OP_G_SET: begin
				bp_q <= brk_q;
				sz_q <= gsz;
			end
			OP_P_LOAD: sz_q <= rsz;
			OP_F_HDR: begin
				hdr_q <= rdata;
				sz_q  <= rsz;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.clr_last   = (clr_q == WAW'(DEPTH - 1));
		stat.kind_free  = kind_q;
		stat.req_zero   = zero_q;
		stat.bp_ge_brk  = (bp_q >= brk_q);
		stat.nx_ge_brk  = (nx_q >= brk_q);
		stat.r_zero     = (rsz == '0);
		stat.r_alloc    = rdata[0];
		stat.r_fit      = (rsz >= need_q);
		stat.tot_ne_sz  = (total_q != sz_q);
		stat.grow_fail  = (gsz > HEAP_B) || (brk_sum > {1'b0, HEAP_B});
		stat.split_ok   = ((sz_q - need_q) >= MIN_B);
		stat.f_bad_addr = (bp_q[2:0] != 3'd0) || (bp_q < BW'(16)) || (bp_q >= brk_q);
		stat.f_bad_hdr  = !rdata[0] || (rsz < HMIN_B) || (rsz > brk_q - bp_q);
		stat.f_ft_bad   = (rdata != hdr_q);
	end

	assign bp_low = bp_q[15:0];
endmodule
`default_nettype wire

/* rtl/ilha_ctl.sv */
// Controller: sequences clear, walks, merge sweep, growth, placement and free.
`default_nettype none
module ilha_ctl import ilha_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   take,
	input  stat_t stat,
	output cmd_t  cmd,
	output res_t  res
);
	typedef enum logic [28:0] {
		S_CLR   = 29'd1 << 0,  S_IDLE  = 29'd1 << 1,  S_DISP  = 29'd1 << 2,
		S_W_RD  = 29'd1 << 3,  S_W_DAT = 29'd1 << 4,  S_M_RD  = 29'd1 << 5,
		S_M_DAT = 29'd1 << 6,  S_N_RD  = 29'd1 << 7,  S_N_DAT = 29'd1 << 8,
		S_M_END = 29'd1 << 9,  S_M_FT  = 29'd1 << 10, S_G_CHK = 29'd1 << 11,
		S_G_H   = 29'd1 << 12, S_G_F   = 29'd1 << 13, S_G_E   = 29'd1 << 14,
		S_P_RD  = 29'd1 << 15, S_P_DAT = 29'd1 << 16, S_P_DEC = 29'd1 << 17,
		S_SH1   = 29'd1 << 18, S_SF1   = 29'd1 << 19, S_SH2   = 29'd1 << 20,
		S_SF2   = 29'd1 << 21, S_NH    = 29'd1 << 22, S_NF    = 29'd1 << 23,
		S_F_CHK = 29'd1 << 24, S_F_HDR = 29'd1 << 25, S_F_FT  = 29'd1 << 26,
		S_F_W1  = 29'd1 << 27, S_F_W2  = 29'd1 << 28
	} state_t;

	state_t state_q, state_d;
	logic   pass_q, pass_d;

	always_comb begin
		state_d       = state_q;
		pass_d        = pass_q;
		cmd.op        = OP_NONE;
		res.idle      = 1'b0;
		res.done      = 1'b0;
		res.with_addr = 1'b0;
		res.code      = ST_OK;
		unique case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				res.idle = 1'b1;
				if (take) begin
					cmd.op  = OP_LATCH;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				priority if (stat.kind_free) begin
					state_d = S_F_CHK;
				end else if (stat.req_zero) begin
					res.done = 1'b1;
					res.code = ST_ZERO;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_BP_START;
					pass_d  = 1'b0;
					state_d = S_W_RD;
				end
			end
			S_W_RD, S_W_DAT: begin
				// walk ends: sweep once, then grow
				if ((state_q == S_W_RD && stat.bp_ge_brk) ||
				    (state_q == S_W_DAT && stat.r_zero)) begin
					if (!pass_q) begin
						cmd.op  = OP_BP_START;
						pass_d  = 1'b1;
						state_d = S_M_RD;
					end else begin
						state_d = S_G_CHK;
					end
				end else if (state_q == S_W_RD) begin
					cmd.op  = OP_RD_BP;
					state_d = S_W_DAT;
				end else if (!stat.r_alloc && stat.r_fit) begin
					cmd.op  = OP_P_LOAD;
					state_d = S_P_DEC;
				end else begin
					cmd.op  = OP_WALK_ADV;
					state_d = S_W_RD;
				end
			end
			S_M_RD: begin
				if (stat.bp_ge_brk) begin
					cmd.op  = OP_BP_START;
					state_d = S_W_RD;
				end else begin
					cmd.op  = OP_RD_BP;
					state_d = S_M_DAT;
				end
			end
			S_M_DAT: begin
				priority if (stat.r_zero) begin
					cmd.op  = OP_BP_START;
					state_d = S_W_RD;
				end else if (stat.r_alloc) begin
					cmd.op  = OP_WALK_ADV;
					state_d = S_M_RD;
				end else begin
					cmd.op  = OP_M_OPEN;
					state_d = S_N_RD;
				end
			end
			S_N_RD: begin
				if (stat.nx_ge_brk) begin
					state_d = S_M_END;
				end else begin
					cmd.op  = OP_RD_NX;
					state_d = S_N_DAT;
				end
			end
			S_N_DAT: begin
				if (stat.r_zero || stat.r_alloc) begin
					state_d = S_M_END;
				end else begin
					cmd.op  = OP_N_ADV;
					state_d = S_N_RD;
				end
			end
			S_M_END: begin
				if (stat.tot_ne_sz) begin
					cmd.op  = OP_WR_MH;
					state_d = S_M_FT;
				end else begin
					cmd.op  = OP_M_NEXT;
					state_d = S_M_RD;
				end
			end
			S_M_FT: begin
				cmd.op  = OP_WR_MF;
				state_d = S_M_RD;
			end
			S_G_CHK: begin
				if (stat.grow_fail) begin
					res.done = 1'b1;
					res.code = ST_FULL;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_G_SET;
					state_d = S_G_H;
				end
			end
			S_G_H: begin
				cmd.op  = OP_WR_GH;
				state_d = S_G_F;
			end
			S_G_F: begin
				cmd.op  = OP_WR_GF;
				state_d = S_G_E;
			end
			S_G_E: begin
				cmd.op  = OP_WR_GE;
				state_d = S_P_RD;
			end
			S_P_RD: begin
				cmd.op  = OP_RD_BP;
				state_d = S_P_DAT;
			end
			S_P_DAT: begin
				cmd.op  = OP_P_LOAD;
				state_d = S_P_DEC;
			end
			S_P_DEC: state_d = stat.split_ok ? S_SH1 : S_NH;
			S_SH1: begin
				cmd.op  = OP_WR_SH1;
				state_d = S_SF1;
			end
			S_SF1: begin
				cmd.op  = OP_WR_SF1;
				state_d = S_SH2;
			end
			S_SH2: begin
				cmd.op  = OP_WR_SH2;
				state_d = S_SF2;
			end
			S_SF2, S_NF: begin
				cmd.op        = (state_q == S_SF2) ? OP_WR_SF2 : OP_WR_NF;
				res.done      = 1'b1;
				res.with_addr = 1'b1;
				state_d       = S_IDLE;
			end
			S_NH: begin
				cmd.op  = OP_WR_NH;
				state_d = S_NF;
			end
			S_F_CHK: begin
				if (stat.f_bad_addr) begin
					res.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_RD_BP;
					state_d = S_F_HDR;
				end
			end
			S_F_HDR: begin
				if (stat.f_bad_hdr) begin
					res.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_F_HDR;
					state_d = S_F_FT;
				end
			end
			S_F_FT: begin
				if (stat.f_ft_bad) begin
					res.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					state_d = S_F_W1;
				end
			end
			S_F_W1: begin
				cmd.op  = OP_WR_FH;
				state_d = S_F_W2;
			end
			S_F_W2: begin
				cmd.op   = OP_WR_FF;
				res.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end
endmodule
`default_nettype wire

/* rtl/implicit_list_heap_allocator.sv */
// Top level: first-fit boundary-tag heap allocator with result register.
//
//  channel  dir  transfer on        payload
//  req      in   valid & ready      kind, request_bytes, block_addr
//  rsp      out  valid & ready      payload_addr, status
//  cfg      in   cfg_we             cfg_wdata -> chunk_bytes
//
// One item at a time. An allocate visits blocks on the single RAM port (address, registered
// data), over one walk, or two walks and a merge sweep that adds two writes per merged run;
// growth then checks the heap limit, writes header, footer and epilogue, reads the block back,
// and placement splits the block or marks it whole. A zero-size request answers without a
// walk; a free checks address, header and footer before it writes header and footer.
// After reset the RAM is cleared and seeded before req opens.
// req stays low while a result waits in the output register and rsp is stalled.
`default_nettype none
module implicit_list_heap_allocator import ilha_pkg::*; #(
	parameter int HEAP_BYTES      = 65536,
	parameter int MIN_BLOCK_BYTES = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	ilha_req_if.sink   req,
	ilha_rsp_if.source rsp,
	input  wire        cfg_we,
	input  wire [16:0] cfg_wdata
);
	cmd_t        cmd;
	stat_t       stat;
	res_t        res;
	logic [15:0] bp_low;
	logic        take;
	logic        ov_q;
	logic [15:0] addr_q;
	logic [1:0]  code_q;

	assign req.ready = res.idle && (!ov_q || rsp.ready);
	assign take      = req.valid && req.ready;

	ilha_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.stat   (stat),
		.cmd    (cmd),
		.res    (res)
	);

	ilha_dp #(
		.HEAP_BYTES      (HEAP_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.in_kind          (req.kind),
		.in_request_bytes (req.request_bytes),
		.in_block_addr    (req.block_addr),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.bp_low           (bp_low)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res.done) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	// hold the result until the transfer
	always_ff @(posedge clk) begin
		if (res.done) begin
			addr_q <= res.with_addr ? bp_low : 16'd0;
			code_q <= res.code;
		end
	end

	assign rsp.valid        = ov_q;
	assign rsp.payload_addr = addr_q;
	assign rsp.status       = code_q;
endmodule
`default_nettype wire
